### hw/rtl/assert_macros.svh
// Assertion macros shared by the cipher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property on clk, disabled during reset.
`define SPECK_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Overlapping implication on clk, disabled during reset.
`define SPECK_ASSERT_IMPL(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication on clk, disabled during reset.
`define SPECK_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### hw/rtl/speck_pkg.sv
// Shared types and constants for the Speck128/256 cipher.
package speck_pkg;

	localparam int WORD_W          = 64;
	localparam int NUM_ROUNDS      = 34;
	localparam int LAST_ROUND      = NUM_ROUNDS - 1;
	localparam int RND_W           = $clog2(NUM_ROUNDS);
	localparam int NUM_KEY_WORDS   = 4;
	localparam int NUM_SCHED_WORDS = NUM_KEY_WORDS - 1;
	localparam int ROT_X           = 8;
	localparam int ROT_Y           = 3;
	localparam int CFG_ADDR_W      = 8;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} op_t;

	localparam logic [CFG_ADDR_W-1:0] REG_KEY_WORD0 = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_WORD1 = CFG_ADDR_W'(1);
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_WORD2 = CFG_ADDR_W'(2);
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_WORD3 = CFG_ADDR_W'(3);

	// Shift commands for the round key ring.
	typedef struct packed {
		logic fwd;
		logic bwd;
	} ring_ctrl_t;

endpackage

### hw/rtl/speck_if.sv
// Channel interfaces: block request, block response and configuration write.
interface speck_in_if;
	import speck_pkg::*;
	logic  valid;
	logic  ready;
	op_t   opcode;
	word_t block_x;
	word_t block_y;
	modport source(output valid, output opcode, output block_x, output block_y, input ready);
	modport sink(input valid, input opcode, input block_x, input block_y, output ready);
endinterface

interface speck_out_if;
	import speck_pkg::*;
	logic  valid;
	logic  ready;
	word_t result_x;
	word_t result_y;
	modport source(output valid, output result_x, output result_y, input ready);
	modport sink(input valid, input result_x, input result_y, output ready);
endinterface

interface speck_cfg_if;
	import speck_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	word_t                 data;
	modport source(output valid, output addr, output data, input ready);
	modport sink(input valid, input addr, input data, output ready);
endinterface

### hw/rtl/speck_key_cell.sv
// One cell of the round key ring: holds a round key, shifts either way.
module speck_key_cell (
	input  logic                   clk,
	input  speck_pkg::ring_ctrl_t  ctrl,
	input  speck_pkg::word_t       from_next,
	input  speck_pkg::word_t       from_prev,
	output speck_pkg::word_t       key
);
	import speck_pkg::*;

	word_t key_q;

	always_ff @(posedge clk) begin
		if (ctrl.fwd) begin
			key_q <= from_next;
		end else if (ctrl.bwd) begin
			key_q <= from_prev;
		end
	end

	assign key = key_q;

endmodule

### hw/rtl/speck_round.sv
// Speck round function, forward or inverse, one round of combinational logic.
module speck_round (
	input  speck_pkg::word_t x,
	input  speck_pkg::word_t y,
	input  speck_pkg::word_t k,
	input  logic             inv,
	output speck_pkg::word_t x_o,
	output speck_pkg::word_t y_o
);
	import speck_pkg::*;

	word_t fx, fy;
	word_t t, iy, d, ix;

	always_comb begin
		// forward: x = (ror8(x) + y) ^ k ; y = rol3(y) ^ x
		fx = ({x[ROT_X-1:0], x[WORD_W-1:ROT_X]} + y) ^ k;
		fy = {y[WORD_W-1-ROT_Y:0], y[WORD_W-1:WORD_W-ROT_Y]} ^ fx;
		// inverse: y = ror3(y ^ x) ; x = rol8((x ^ k) - y)
		t  = y ^ x;
		iy = {t[ROT_Y-1:0], t[WORD_W-1:ROT_Y]};
		d  = (x ^ k) - iy;
		ix = {d[WORD_W-1-ROT_X:0], d[WORD_W-1:WORD_W-ROT_X]};
		x_o = inv ? ix : fx;
		y_o = inv ? iy : fy;
	end

endmodule

### hw/rtl/speck_block_cipher.sv
// Top level of the Speck128/256 block cipher.
// Speck128/256 cipher, one block at a time through a single shared round unit.
// The 34 round keys live in a ring of key cells that rotates one place per cycle
// in the run state: forward for encryption (key read at cell 0), backward for
// decryption (key read at the last cell), so the ring is back in place when the
// block is done. A request is taken only when the core is idle; it then runs
// through the round unit and moves into the output register, first waiting while
// that register still holds an unaccepted result, so a new request can be
// accepted while an earlier result waits there. After any key register write, the
// next request first expands the key, using the same round unit and shifting each
// key into the ring. Configuration writes are always ready and must be issued only
// when no request is in flight; indexes above 3 are ignored.
`include "assert_macros.svh"

module speck_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	speck_cfg_if.sink   cfg,
	speck_in_if.sink    req,
	speck_out_if.source rsp
);
	import speck_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_RUN,
		ST_DRAIN
	} state_t;

	state_t                   state_q;
	logic [RND_W-1:0]         rnd_q;
	logic                     key_pending_q;
	logic                     rsp_valid_q;
	word_t                    key_word_q [NUM_KEY_WORDS];
	logic [NUM_KEY_WORDS-1:0] cfg_sel;

	word_t a_q;
	word_t l_q [NUM_SCHED_WORDS];
	word_t x_q, y_q;
	op_t   op_q;
	word_t res_x_q, res_y_q;

	word_t      rk      [NUM_ROUNDS];
	word_t      rk_next [NUM_ROUNDS];
	word_t      rk_prev [NUM_ROUNDS];
	word_t      tail_feed;
	ring_ctrl_t ring_ctrl;

	word_t rnd_x_in, rnd_y_in, rnd_k, rnd_x, rnd_y;
	logic  rnd_inv;
	logic  last_rnd;
	logic  slot_free;

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;

	always_comb begin
		cfg_sel = '0;
		if (cfg.valid) begin
			unique case (cfg.addr)
				REG_KEY_WORD0: cfg_sel[0] = 1'b1;
				REG_KEY_WORD1: cfg_sel[1] = 1'b1;
				REG_KEY_WORD2: cfg_sel[2] = 1'b1;
				REG_KEY_WORD3: cfg_sel[3] = 1'b1;
				default:       cfg_sel    = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_KEY_WORDS; j++) begin
				key_word_q[j] <= '0;
			end
		end else begin
			for (int j = 0; j < NUM_KEY_WORDS; j++) begin
				if (cfg_sel[j]) begin
					key_word_q[j] <= cfg.data;
				end
			end
		end
	end

	// ---------------- key ring ----------------
	// During expansion the running key word enters at the tail; otherwise the ring wraps.
	assign tail_feed     = (state_q == ST_EXPAND) ? a_q : rk[0];
	assign ring_ctrl.fwd = (state_q == ST_EXPAND) || ((state_q == ST_RUN) && (op_q == OP_ENCRYPT));
	assign ring_ctrl.bwd = (state_q == ST_RUN) && (op_q == OP_DECRYPT);

	for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_ring
		if (i == NUM_ROUNDS - 1) begin : g_tail
			assign rk_next[i] = tail_feed;
		end else begin : g_mid
			assign rk_next[i] = rk[i+1];
		end
		if (i == 0) begin : g_head
			assign rk_prev[i] = rk[NUM_ROUNDS-1];
		end else begin : g_body
			assign rk_prev[i] = rk[i-1];
		end
		speck_key_cell u_cell (
			.clk       (clk),
			.ctrl      (ring_ctrl),
			.from_next (rk_next[i]),
			.from_prev (rk_prev[i]),
			.key       (rk[i])
		);
	end

	// ---------------- shared round unit ----------------
	// Key schedule step: x = schedule word, y = running key, k = round index.
	always_comb begin
		if (state_q == ST_EXPAND) begin
			rnd_x_in = l_q[0];
			rnd_y_in = a_q;
			rnd_k    = WORD_W'(rnd_q);
			rnd_inv  = 1'b0;
		end else begin
			rnd_x_in = x_q;
			rnd_y_in = y_q;
			rnd_k    = (op_q == OP_DECRYPT) ? rk[NUM_ROUNDS-1] : rk[0];
			rnd_inv  = (op_q == OP_DECRYPT);
		end
	end

	speck_round u_round (
		.x   (rnd_x_in),
		.y   (rnd_y_in),
		.k   (rnd_k),
		.inv (rnd_inv),
		.x_o (rnd_x),
		.y_o (rnd_y)
	);

	assign last_rnd  = (rnd_q == RND_W'(LAST_ROUND));
	assign slot_free = !rsp_valid_q || rsp.ready;

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rnd_q         <= '0;
			key_pending_q <= 1'b1; // reset key is all zero; expand it on first use
			rsp_valid_q   <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						rnd_q   <= '0;
						state_q <= key_pending_q ? ST_EXPAND : ST_RUN;
					end
				end
				ST_EXPAND: begin
					if (last_rnd) begin
						rnd_q         <= '0;
						key_pending_q <= 1'b0;
						state_q       <= ST_RUN;
					end else begin
						rnd_q <= rnd_q + RND_W'(1);
					end
				end
				ST_RUN: begin
					if (last_rnd) begin
						rnd_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						rnd_q <= rnd_q + RND_W'(1);
					end
				end
				ST_DRAIN: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (|cfg_sel) begin
				key_pending_q <= 1'b1;
			end
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					x_q  <= req.block_x;
					y_q  <= req.block_y;
					op_q <= req.opcode;
					a_q  <= key_word_q[0];
					for (int j = 0; j < NUM_SCHED_WORDS; j++) begin
						l_q[j] <= key_word_q[j+1];
					end
				end
			end
			ST_EXPAND: begin
				a_q <= rnd_y;
				for (int j = 0; j < NUM_SCHED_WORDS - 1; j++) begin
					l_q[j] <= l_q[j+1];
				end
				l_q[NUM_SCHED_WORDS-1] <= rnd_x;
			end
			ST_RUN: begin
				x_q <= rnd_x;
				y_q <= rnd_y;
			end
			ST_DRAIN: begin
				if (slot_free) begin
					res_x_q <= x_q;
					res_y_q <= y_q;
				end
			end
			default: ;
		endcase
	end

	assign req.ready    = (state_q == ST_IDLE);
	assign rsp.valid    = rsp_valid_q;
	assign rsp.result_x = res_x_q;
	assign rsp.result_y = res_y_q;

	// ---------------- assertions ----------------
	`SPECK_ASSERT(a_rnd_range, rnd_q <= RND_W'(LAST_ROUND), "round counter out of range")
	`SPECK_ASSERT_NEXT(a_expand_to_run, (state_q == ST_EXPAND) && last_rnd, (state_q == ST_RUN) && (rnd_q == '0), "expansion did not hand over to rounds")
	`SPECK_ASSERT_NEXT(a_run_to_drain, (state_q == ST_RUN) && last_rnd, state_q == ST_DRAIN, "rounds did not end in drain")
	`SPECK_ASSERT_IMPL(a_rsp_from_drain, $rose(rsp_valid_q), $past(state_q == ST_DRAIN), "response raised outside drain")

endmodule

### dv/speck_checker.sv
// Watches the cipher channels, predicts each result from the key state and checks it.
module speck_checker (
	input  logic  clk,
	input  logic  arst_n,
	speck_cfg_if  cfg,
	speck_in_if   req,
	speck_out_if  rsp,
	output int    mismatches,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import speck_pkg::*;

	typedef struct packed {
		word_t x;
		word_t y;
	} block_pair_t;

	word_t       key_reg [NUM_KEY_WORDS];
	word_t       round_key [NUM_ROUNDS];
	bit          rekey_due;
	block_pair_t expected_blocks [$];

	function automatic void speck_fwd(inout word_t x, inout word_t y, input word_t k);
		x = ((x >> ROT_X) | (x << (WORD_W - ROT_X))) + y;
		x = x ^ k;
		y = ((y << ROT_Y) | (y >> (WORD_W - ROT_Y))) ^ x;
	endfunction

	function automatic void speck_inv(inout word_t x, inout word_t y, input word_t k);
		y = y ^ x;
		y = (y >> ROT_Y) | (y << (WORD_W - ROT_Y));
		x = (x ^ k) - y;
		x = (x << ROT_X) | (x >> (WORD_W - ROT_X));
	endfunction

	// Key schedule: the running word is pushed through the round function with the
	// three other key words in rotation, round index as the key.
	function automatic void expand_schedule();
		word_t a;
		word_t l [NUM_SCHED_WORDS];
		a = key_reg[0];
		for (int j = 0; j < NUM_SCHED_WORDS; j++)
			l[j] = key_reg[j + 1];
		for (int i = 0; i < NUM_ROUNDS; i++) begin
			round_key[i] = a;
			if (i < LAST_ROUND)
				speck_fwd(l[i % NUM_SCHED_WORDS], a, word_t'(i));
		end
	endfunction

	function automatic block_pair_t cipher_block(op_t op, word_t x, word_t y);
		block_pair_t r;
		if (op == OP_ENCRYPT) begin
			for (int i = 0; i < NUM_ROUNDS; i++)
				speck_fwd(x, y, round_key[i]);
		end else begin
			for (int i = LAST_ROUND; i >= 0; i--)
				speck_inv(x, y, round_key[i]);
		end
		r.x = x;
		r.y = y;
		return r;
	endfunction

	function automatic void check_half(string field, word_t want, word_t got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		block_pair_t want;
		if (!arst_n) begin
			foreach (key_reg[i])
				key_reg[i] = '0;
			expand_schedule();
			rekey_due = 1'b0;
			expected_blocks.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready && cfg.addr < NUM_KEY_WORDS) begin
				key_reg[cfg.addr[1:0]] = cfg.data;
				rekey_due = 1'b1;
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_blocks.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual x=%h y=%h",
						$time, rsp.result_x, rsp.result_y);
				end else begin
					want = expected_blocks.pop_front();
					check_half("result_x", want.x, rsp.result_x);
					check_half("result_y", want.y, rsp.result_y);
				end
			end
			if (req.valid && req.ready) begin
				// new key takes effect on the first block after the write
				if (rekey_due) begin
					expand_schedule();
					rekey_due = 1'b0;
				end
				expected_blocks.push_back(cipher_block(req.opcode, req.block_x, req.block_y));
			end
			pending = expected_blocks.size();
		end
	end

endmodule

### dv/tb_top.sv
// Stimulus, clock, reset and verdict for the Speck128/256 cipher block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import speck_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int NUM_PHASES   = 40;
	localparam int CALM_PHASE   = 6;
	localparam int HOLD_PHASE   = 12;
	localparam int PAUSE_PHASE  = 18;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = 80;
	localparam int IDLE_PCT     = 21;
	localparam int MAX_GAP      = 45;
	localparam int UNUSED_LO    = NUM_KEY_WORDS;
	localparam int UNUSED_HI    = (1 << CFG_ADDR_W) - 1;
	localparam word_t ONES      = '1;
	localparam word_t TOP_BIT   = word_t'(1) << (WORD_W - 1);

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	bit   hold_go;
	int   cycle_count;
	int   mismatches;
	int   pending;

	speck_cfg_if cfg_ch ();
	speck_in_if  req_ch ();
	speck_out_if rsp_ch ();

	speck_block_cipher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	speck_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_ch),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic word_t rand_word();
		case ($urandom_range(9))
			0: return '0;
			1: return ONES;
			2: return word_t'(1) << $urandom_range(WORD_W - 1);
			3: return ~(word_t'(1) << $urandom_range(WORD_W - 1));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_block(op_t op, word_t x, word_t y);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(MAX_GAP, 1)) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.opcode  <= op;
		req_ch.block_x <= x;
		req_ch.block_y <= y;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Stop offering and wait for every outstanding result; returns on a rising edge.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, word_t data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= addr;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Response side: random backpressure plus one long hold-off on request.
	initial begin : sink_side
		int hold;
		bit hold_done;
		hold = 0;
		hold_done = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		int n;
		arst_n         <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.opcode  <= OP_ENCRYPT;
		req_ch.block_x <= '0;
		req_ch.block_y <= '0;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.addr    <= '0;
		cfg_ch.data    <= '0;
		calm           <= 1'b0;
		hold_go        <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key schedule
		send_block(OP_ENCRYPT, '0, '0);
		send_block(OP_DECRYPT, '0, '0);
		send_block(OP_ENCRYPT, ONES, ONES);
		send_block(OP_DECRYPT, ONES, ONES);

		// published test vector key
		drain();
		write_reg(REG_KEY_WORD0, 64'h0706050403020100);
		write_reg(REG_KEY_WORD1, 64'h0f0e0d0c0b0a0908);
		write_reg(REG_KEY_WORD2, 64'h1716151413121110);
		write_reg(REG_KEY_WORD3, 64'h1f1e1d1c1b1a1918);
		send_block(OP_ENCRYPT, 64'h65736f6874206e49, 64'h202e72656e6f6f70);
		send_block(OP_DECRYPT, 64'h4109010405c0f53e, 64'h4eeeb48d9c188f43);
		send_block(OP_ENCRYPT, TOP_BIT, word_t'(1));
		send_block(OP_DECRYPT, word_t'(1), TOP_BIT);

		// all-ones key
		drain();
		write_reg(REG_KEY_WORD0, ONES);
		write_reg(REG_KEY_WORD1, ONES);
		write_reg(REG_KEY_WORD2, ONES);
		write_reg(REG_KEY_WORD3, ONES);
		send_block(OP_ENCRYPT, '0, ONES);
		send_block(OP_DECRYPT, ONES, '0);

		// single-word rewrite mixed with ignored out-of-range indexes
		drain();
		write_reg(CFG_ADDR_W'(UNUSED_LO), '0);
		write_reg(REG_KEY_WORD2, '0);
		write_reg(CFG_ADDR_W'(UNUSED_HI), '0);
		send_block(OP_ENCRYPT, rand_word(), rand_word());
		send_block(OP_DECRYPT, rand_word(), rand_word());

		// ignored write alone must not disturb the schedule
		drain();
		write_reg(CFG_ADDR_W'(UNUSED_LO), ONES);
		send_block(OP_ENCRYPT, {$urandom, $urandom}, {$urandom, $urandom});

		// back to the zero key through writes
		drain();
		write_reg(REG_KEY_WORD0, '0);
		write_reg(REG_KEY_WORD1, '0);
		write_reg(REG_KEY_WORD3, '0);
		send_block(OP_ENCRYPT, '0, '0);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			calm <= (ph == CALM_PHASE);
			if (ph == HOLD_PHASE)
				hold_go <= 1'b1;
			for (int r = 0; r < NUM_KEY_WORDS; r++)
				if ($urandom_range(1))
					write_reg(CFG_ADDR_W'(r), rand_word());
			if ($urandom_range(7) == 0)
				write_reg(CFG_ADDR_W'($urandom_range(UNUSED_HI, UNUSED_LO)), rand_word());
			n = (ph == CALM_PHASE) ? 80 : $urandom_range(70, 30);
			for (int i = 0; i < n; i++) begin
				if (ph == PAUSE_PHASE && i == n / 2)
					drain();
				send_block(op_t'($urandom_range(1)), rand_word(), rand_word());
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
